// ===== src/rcwct_pkg.sv =====
// Shared types, constants and field layout for the wall column texturer.
package rcwct_pkg;

    localparam int TEXTURE_WIDTH  = 64;
    localparam int TEXTURE_HEIGHT = 64;
    localparam int NUM_FACES      = 4;

    localparam int TXC_W   = $clog2(TEXTURE_WIDTH);
    localparam int TY_W    = $clog2(TEXTURE_HEIGHT);
    localparam int FACE_W  = $clog2(NUM_FACES);
    localparam int ADDR_W  = FACE_W + TY_W + TXC_W;
    localparam int DEPTH   = NUM_FACES * TEXTURE_WIDTH * TEXTURE_HEIGHT;
    localparam int COLOR_W = 24;
    localparam int ROW_W   = 10;
    localparam int POS_W   = 24;
    localparam int DIR_W   = 18;
    localparam int HGT_W   = 16;
    localparam int TP_W    = 32;
    localparam int FRAC_W  = 16;
    localparam int STEP_W  = TY_W + FRAC_W + 1;
    localparam int CNT_W   = $clog2(STEP_W);
    localparam int OFF_W   = HGT_W + 1;

    localparam logic [STEP_W-1:0] DIV_NUM = STEP_W'(TEXTURE_HEIGHT) << FRAC_W;
    localparam logic [ROW_W-1:0]  SCREEN_HEIGHT_RST = ROW_W'(480);

    // slave-side tdata layout, lowest bit up
    localparam int IN_COLOR_LO = 0;
    localparam int IN_FACE_LO  = IN_COLOR_LO + COLOR_W;
    localparam int IN_PX_LO    = IN_FACE_LO + FACE_W;
    localparam int IN_PY_LO    = IN_PX_LO + POS_W;
    localparam int IN_DX_LO    = IN_PY_LO + POS_W;
    localparam int IN_DY_LO    = IN_DX_LO + DIR_W;
    localparam int IN_DIST_LO  = IN_DY_LO + DIR_W;
    localparam int IN_HGT_LO   = IN_DIST_LO + POS_W;
    localparam int IN_FIRST_LO = IN_HGT_LO + HGT_W;
    localparam int IN_END_LO   = IN_FIRST_LO + ROW_W;
    localparam int IN_COL_LO   = IN_END_LO + ROW_W;
    localparam int IN_BITS     = IN_COL_LO + ROW_W;
    localparam int S_DATA_W    = ((IN_BITS + 7) / 8) * 8;

    localparam int OUT_BITS    = 2 * ROW_W + COLOR_W;
    localparam int M_DATA_W    = ((OUT_BITS + 7) / 8) * 8;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_START = 2'd1,
        OP_TICK  = 2'd2
    } opcode_t;

    typedef enum logic [1:0] {
        SU_IDLE,
        SU_MUL,
        SU_DIV,
        SU_POS
    } setup_state_t;

    typedef struct packed {
        logic [FACE_W-1:0]       face;
        logic [POS_W-1:0]        pos;
        logic signed [DIR_W-1:0] dir;
        logic [POS_W-1:0]        distance;
        logic [HGT_W-1:0]        height;
        logic [ROW_W-1:0]        first_row;
        logic [ROW_W-1:0]        end_row;
        logic [ROW_W-1:0]        column;
        logic [ROW_W-2:0]        half_screen;
    } setup_req_t;

    typedef struct packed {
        logic                    done;
        logic [FACE_W-1:0]       face;
        logic [TXC_W-1:0]        tex_col;
        logic [TP_W-1:0]         step;
        logic [TP_W-1:0]         position;
        logic [ROW_W-1:0]        first_row;
        logic [ROW_W-1:0]        stop_row;
        logic [ROW_W-1:0]        column;
    } setup_res_t;

endpackage

// ===== src/rcwct_tex_mem.sv =====
// Texture store: one write port, one registered read port.
module rcwct_tex_mem
    import rcwct_pkg::*;
(
    input  logic               aclk,
    input  logic               we,
    input  logic [ADDR_W-1:0]  waddr,
    input  logic [COLOR_W-1:0] wdata,
    input  logic               re,
    input  logic [ADDR_W-1:0]  raddr,
    output logic [COLOR_W-1:0] rdata
);

    logic [COLOR_W-1:0] mem [DEPTH];
    logic [COLOR_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/rcwct_setup.sv =====
// Column setup: hit coordinate, texture column, serial step divider, start position.
module rcwct_setup
    import rcwct_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       start,
    input  setup_req_t req,
    output logic       busy,
    output setup_res_t res
);

    setup_state_t               state_reg, state_next;
    setup_req_t                 req_reg;
    setup_req_t                 req_in;
    logic [TP_W-1:0]            prod_reg;
    logic [TXC_W-1:0]           tcol_reg;
    logic [CNT_W-1:0]           cnt_reg;
    logic [HGT_W-1:0]           rem_reg;
    logic [STEP_W-1:0]          quo_reg;

    logic [HGT_W:0]             trial;
    logic [TP_W-1:0]            frac;
    logic [TXC_W-1:0]           tx;
    logic signed [OFF_W-1:0]    offset;
    logic signed [OFF_W+STEP_W:0] pos_prod;
    logic signed [POS_W+DIR_W:0]  hit_prod;

    assign hit_prod = $signed({1'b0, req_reg.distance}) * $signed(req_reg.dir);
    assign frac     = {req_reg.pos[FRAC_W-1:0], {FRAC_W{1'b0}}} + prod_reg;
    assign tx       = req_reg.face[0] ? ~frac[TP_W-1 -: TXC_W] : frac[TP_W-1 -: TXC_W];
    assign trial    = {rem_reg, DIV_NUM[cnt_reg]};
    assign offset   = $signed(OFF_W'(req_reg.first_row))
                    - $signed(OFF_W'(req_reg.half_screen))
                    + $signed(OFF_W'(req_reg.height[HGT_W-1:1]));
    assign pos_prod = offset * $signed({1'b0, quo_reg});

    always_comb begin
        req_in = req;
        if (req.height == '0) begin
            req_in.height = HGT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= SU_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            SU_IDLE: if (start) state_next = SU_MUL;
            SU_MUL:  state_next = SU_DIV;
            SU_DIV:  if (cnt_reg == '0) state_next = SU_POS;
            SU_POS:  state_next = SU_IDLE;
            default: state_next = SU_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            SU_IDLE: begin
                if (start) begin
                    req_reg <= req_in;
                end
            end
            SU_MUL: begin
                prod_reg <= hit_prod[TP_W-1:0];
                rem_reg  <= '0;
                quo_reg  <= '0;
                cnt_reg  <= CNT_W'(STEP_W - 1);
            end
            SU_DIV: begin
                tcol_reg <= tx;
                cnt_reg  <= cnt_reg - CNT_W'(1);
                if (trial >= {1'b0, req_reg.height}) begin
                    rem_reg <= HGT_W'(trial - {1'b0, req_reg.height});
                    quo_reg <= {quo_reg[STEP_W-2:0], 1'b1};
                end else begin
                    rem_reg <= trial[HGT_W-1:0];
                    quo_reg <= {quo_reg[STEP_W-2:0], 1'b0};
                end
            end
            default: begin
            end
        endcase
    end

    assign busy          = (state_reg != SU_IDLE);
    assign res.done      = (state_reg == SU_POS);
    assign res.face      = req_reg.face;
    assign res.tex_col   = tcol_reg;
    assign res.step      = TP_W'(quo_reg);
    assign res.position  = pos_prod[TP_W-1:0];
    assign res.first_row = req_reg.first_row;
    assign res.stop_row  = req_reg.end_row;
    assign res.column    = req_reg.column;

endmodule

// ===== src/raycast_wall_column_texturer_unit.sv =====
// Top level of the textured wall column generator.
// A texel load or a pixel tick is taken every cycle while no column setup runs and
// the read stage can move on; a pixel word leaves through a read stage and then an
// output register, so ticks stream at one per cycle while the sink keeps up. A column
// start holds s_tready low while the setup runs: the hit product, the step divider
// that retires one quotient bit per cycle (23 bits) and the start-position product.
// Texels must be loaded before they are drawn; the store has no reset.
module raycast_wall_column_texturer_unit
    import rcwct_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    // texel_color, hit_face, player_x, player_y, ray_dir_x, ray_dir_y, wall_dist,
    // slice_height, first_row, end_row, column, zero fill
    input  logic [S_DATA_W-1:0] s_tdata,
    // opcode
    input  logic [1:0]          s_tuser,
    output logic                m_tvalid,
    input  logic                m_tready,
    // out_row, out_column, pixel_color, zero fill
    output logic [M_DATA_W-1:0] m_tdata,
    output logic                m_tlast,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    logic [ROW_W-1:0]   screen_height_reg;
    logic [ADDR_W-1:0]  load_addr_reg;
    logic [FACE_W-1:0]  face_reg;
    logic [TXC_W-1:0]   tcol_reg;
    logic [TP_W-1:0]    tpos_reg;
    logic [TP_W-1:0]    step_reg;
    logic [ROW_W-1:0]   cur_row_reg;
    logic [ROW_W-1:0]   stop_row_reg;
    logic [ROW_W-1:0]   column_reg;
    logic               rd_valid_reg;
    logic [ROW_W-1:0]   rd_row_reg;
    logic [ROW_W-1:0]   rd_col_reg;
    logic               rd_last_reg;
    logic               m_valid_reg;
    logic [ROW_W-1:0]   m_row_reg;
    logic [ROW_W-1:0]   m_col_reg;
    logic [COLOR_W-1:0] m_color_reg;
    logic               m_last_reg;

    opcode_t            op;
    logic               fire;
    logic               out_adv;
    logic               col_active;
    logic               load_go;
    logic               start_go;
    logic               tick_go;
    logic               setup_busy;
    logic [ADDR_W-1:0]  raddr;
    logic [COLOR_W-1:0] rdata;
    setup_req_t         req;
    setup_res_t         res;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? 32'(screen_height_reg) : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            screen_height_reg <= SCREEN_HEIGHT_RST;
        end else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
            screen_height_reg <= pwdata[ROW_W-1:0];
        end
    end

    assign op         = opcode_t'(s_tuser);
    assign out_adv    = !m_valid_reg || m_tready;
    assign s_tready   = !setup_busy && (!rd_valid_reg || out_adv);
    assign fire       = s_tvalid && s_tready;
    assign col_active = cur_row_reg < stop_row_reg;

    always_comb begin
        load_go  = 1'b0;
        start_go = 1'b0;
        tick_go  = 1'b0;
        unique case (op)
            OP_LOAD:  load_go  = fire;
            OP_START: start_go = fire;
            OP_TICK:  tick_go  = fire && col_active;
            default: begin
            end
        endcase
    end

    assign req.face        = s_tdata[IN_FACE_LO +: FACE_W];
    assign req.pos         = s_tdata[IN_FACE_LO + 1] ? s_tdata[IN_PY_LO +: POS_W]
                                                     : s_tdata[IN_PX_LO +: POS_W];
    assign req.dir         = s_tdata[IN_FACE_LO + 1] ? $signed(s_tdata[IN_DY_LO +: DIR_W])
                                                     : $signed(s_tdata[IN_DX_LO +: DIR_W]);
    assign req.distance    = s_tdata[IN_DIST_LO +: POS_W];
    assign req.height      = s_tdata[IN_HGT_LO +: HGT_W];
    assign req.first_row   = s_tdata[IN_FIRST_LO +: ROW_W];
    assign req.end_row     = s_tdata[IN_END_LO +: ROW_W];
    assign req.column      = s_tdata[IN_COL_LO +: ROW_W];
    assign req.half_screen = screen_height_reg[ROW_W-1:1];

    rcwct_setup u_setup (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (start_go),
        .req     (req),
        .busy    (setup_busy),
        .res     (res)
    );

    assign raddr = {face_reg, tpos_reg[FRAC_W +: TY_W], tcol_reg};

    rcwct_tex_mem u_tex_mem (
        .aclk  (aclk),
        .we    (load_go),
        .waddr (load_addr_reg),
        .wdata (s_tdata[IN_COLOR_LO +: COLOR_W]),
        .re    (tick_go),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            load_addr_reg <= '0;
            face_reg      <= '0;
            tcol_reg      <= '0;
            tpos_reg      <= '0;
            step_reg      <= '0;
            cur_row_reg   <= '0;
            stop_row_reg  <= '0;
            column_reg    <= '0;
        end else begin
            if (load_go) begin
                load_addr_reg <= load_addr_reg + ADDR_W'(1);
            end
            if (res.done) begin
                face_reg     <= res.face;
                tcol_reg     <= res.tex_col;
                tpos_reg     <= res.position;
                step_reg     <= res.step;
                cur_row_reg  <= res.first_row;
                stop_row_reg <= res.stop_row;
                column_reg   <= res.column;
            end else if (tick_go) begin
                tpos_reg    <= tpos_reg + step_reg;
                cur_row_reg <= cur_row_reg + ROW_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (tick_go) begin
                rd_valid_reg <= 1'b1;
            end else if (out_adv) begin
                rd_valid_reg <= 1'b0;
            end
            if (out_adv) begin
                m_valid_reg <= rd_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (tick_go) begin
            rd_row_reg  <= cur_row_reg;
            rd_col_reg  <= column_reg;
            rd_last_reg <= (cur_row_reg + ROW_W'(1)) == stop_row_reg;
        end
        if (out_adv && rd_valid_reg) begin
            m_row_reg   <= rd_row_reg;
            m_col_reg   <= rd_col_reg;
            m_color_reg <= rdata;
            m_last_reg  <= rd_last_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {{(M_DATA_W - OUT_BITS){1'b0}}, m_color_reg, m_col_reg, m_row_reg};

    assert property (@(posedge aclk) disable iff (!aresetn)
        setup_busy |-> !s_tready)
        else $error("word accepted during column setup");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (rd_valid_reg && m_valid_reg && !m_tready) |-> !s_tready)
        else $error("read stage overrun while output stalled");

    assert property (@(posedge aclk) disable iff (!aresetn)
        tick_go |=> rd_valid_reg && (cur_row_reg == $past(cur_row_reg) + ROW_W'(1)))
        else $error("pixel tick did not advance row");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && (op == OP_TICK) && !col_active) |=> !rd_valid_reg || $past(rd_valid_reg))
        else $error("idle tick produced a pixel");

endmodule
